### sv/integer_to_ascii_radix_macros.svh
// assertion macros for the integer_to_ascii_radix block
// used by the top level; no other dependencies
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define ITOA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("itoa assertion failed");
// next-cycle implication, disabled during reset
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("itoa assertion failed");
`else
`define ITOA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/itoa_pkg.sv
// shared types, constants and helper functions of the integer to ascii block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    // conversion modes; code 3 means nothing and yields only the terminator
    typedef enum logic [1:0] {
        FUNC_DEC = 2'd0,
        FUNC_HEX = 2'd1,
        FUNC_OCT = 2'd2
    } t_func;

    localparam int STORE_DEPTH = 11;
    localparam int CNT_W       = 4;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    localparam logic [3:0]  DEC_BASE = 4'd10;
    // ceil(2^16 / 10), exact floor division for dividends below 2560
    localparam logic [24:0] RECIP10  = 25'd6554;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic put_zero;
        logic step;
        logic put_sign;
        logic emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic room_zero;
        logic mag_zero;
        logic cnt_lt_room;
        logic cnt_zero;
        logic digit_last;
        logic neg;
    } t_sts;

    typedef struct packed {
        logic [7:0] q;
        logic [3:0] r;
    } t_div;

    // one byte of long division by ten: {remainder, byte} / 10
    function automatic t_div div10_step(input logic [11:0] t);
        logic [24:0] prod;
        logic [11:0] back;
        t_div        res;
        prod  = {13'd0, t} * RECIP10;
        res.q = prod[23:16];
        back  = ({4'd0, res.q} << 3) + ({4'd0, res.q} << 1);
        res.r = 4'(t - back);
        return res;
    endfunction

    // digit value to lower-case ascii
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < DEC_BASE) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_A + {4'd0, d} - {4'd0, DEC_BASE};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/itoa_ctrl.sv
// controller state machine of the integer to ascii block
// depends on itoa_pkg
`timescale 1ns / 1ps
`default_nettype none

module itoa_ctrl import itoa_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIGIT,
        S_TEST,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.room_zero) begin
                    n_state = S_EMIT;
                end else if (i_sts.mag_zero) begin
                    o_cmd.put_zero = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                o_cmd.step = 1'b1;
                if (i_sts.digit_last) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (!i_sts.mag_zero && i_sts.cnt_lt_room) begin
                    n_state = S_DIGIT;
                end else begin
                    // sign only if room is left after the digits
                    o_cmd.put_sign = i_sts.neg && i_sts.cnt_lt_room;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.cnt_zero) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

### sv/itoa_dp.sv
// datapath of the integer to ascii block: magnitude, digit unit, digit store
// depends on itoa_pkg
`timescale 1ns / 1ps
`default_nettype none

module itoa_dp import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  t_cmd                         i_cmd,
    input  wire  [1:0]                   i_func,
    input  wire  signed [VALUE_WIDTH-1:0] i_value,
    input  wire  [3:0]                   i_max_chars,
    output t_sts                         o_sts,
    output logic                         o_valid,
    output logic [7:0]                   o_char_out,
    output logic                         o_last
);

    localparam int NCHUNK  = (VALUE_WIDTH + 7) / 8;
    localparam int MAG_W   = NCHUNK * 8;
    localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    logic [MAG_W-1:0]   r_mag,   n_mag;
    logic [3:0]         r_rem,   n_rem;
    logic [CHUNK_W-1:0] r_chunk, n_chunk;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [CNT_W-1:0]   r_room,  n_room;
    logic [1:0]         r_func,  n_func;
    logic               r_neg,   n_neg;
    logic               r_valid, n_valid;
    logic [7:0]         r_char,  n_char;
    logic               r_last,  n_last;
    logic [7:0]         r_store [STORE_DEPTH];

    logic [VALUE_WIDTH-1:0] bits;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic                   neg_in;
    logic                   func_ok;
    logic [CNT_W-1:0]       room_raw;
    logic                   chunk_last;
    t_div                   dv;
    logic                   wr_en;
    logic [7:0]             wr_data;
    logic [IDX_W-1:0]       wr_idx;
    logic [IDX_W-1:0]       rd_idx;
    logic [CNT_W-1:0]       cnt_dec;

    assign chunk_last = (r_chunk == CHUNK_W'(NCHUNK - 1));
    assign wr_idx     = r_cnt[IDX_W-1:0];
    assign cnt_dec    = r_cnt - CNT_W'(1);
    assign rd_idx     = cnt_dec[IDX_W-1:0];

    always_comb begin
        bits     = i_value;
        neg_in   = (i_func == FUNC_DEC) && bits[VALUE_WIDTH-1];
        // two's complement negate; most negative value gives its true magnitude
        mag_in   = neg_in ? (VALUE_WIDTH'(0) - bits) : bits;
        func_ok  = (i_func == FUNC_DEC) || (i_func == FUNC_HEX) || (i_func == FUNC_OCT);
        room_raw = (i_max_chars == 4'd0) ? CNT_W'(0) : (i_max_chars - 4'd1);
        if (room_raw > CNT_W'(STORE_DEPTH)) begin
            room_raw = CNT_W'(STORE_DEPTH);
        end

        dv = div10_step({r_rem, r_mag[MAG_W-1 -: 8]});

        n_mag   = r_mag;
        n_rem   = r_rem;
        n_chunk = r_chunk;
        n_cnt   = r_cnt;
        n_room  = r_room;
        n_func  = r_func;
        n_neg   = r_neg;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        wr_en   = 1'b0;
        wr_data = CHAR_NUL;

        if (i_cmd.load) begin
            n_mag   = MAG_W'(mag_in);
            n_rem   = 4'd0;
            n_chunk = '0;
            n_cnt   = '0;
            n_func  = i_func;
            n_neg   = neg_in;
            n_room  = func_ok ? room_raw : CNT_W'(0);
        end

        if (i_cmd.put_zero) begin
            wr_en   = 1'b1;
            wr_data = CHAR_ZERO;
            n_cnt   = r_cnt + CNT_W'(1);
        end

        if (i_cmd.step) begin
            unique case (r_func)
                FUNC_DEC: begin
                    // byte-wise long division, quotient shifts in at the bottom
                    n_mag = (r_mag << 8) | MAG_W'(dv.q);
                    if (chunk_last) begin
                        wr_en   = 1'b1;
                        wr_data = digit_char(dv.r);
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_chunk = '0;
                        n_rem   = 4'd0;
                    end else begin
                        n_rem   = dv.r;
                        n_chunk = r_chunk + CHUNK_W'(1);
                    end
                end
                FUNC_HEX: begin
                    wr_en   = 1'b1;
                    wr_data = digit_char(r_mag[3:0]);
                    n_mag   = r_mag >> 4;
                    n_cnt   = r_cnt + CNT_W'(1);
                end
                FUNC_OCT: begin
                    wr_en   = 1'b1;
                    wr_data = digit_char({1'b0, r_mag[2:0]});
                    n_mag   = r_mag >> 3;
                    n_cnt   = r_cnt + CNT_W'(1);
                end
                default: begin
                    n_mag = r_mag;
                end
            endcase
        end

        if (i_cmd.put_sign) begin
            wr_en   = 1'b1;
            wr_data = CHAR_MINUS;
            n_cnt   = r_cnt + CNT_W'(1);
        end

        if (i_cmd.emit) begin
            n_valid = 1'b1;
            if (r_cnt == CNT_W'(0)) begin
                n_char = CHAR_NUL;
                n_last = 1'b1;
            end else begin
                n_char = r_store[rd_idx];
                n_last = 1'b0;
                n_cnt  = cnt_dec;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_chunk <= '0;
            r_room  <= '0;
            r_mag   <= '0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            r_chunk <= n_chunk;
            r_room  <= n_room;
            r_mag   <= n_mag;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_func <= n_func;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
        if (wr_en) begin
            r_store[wr_idx] <= wr_data;
        end
    end

    assign o_sts.room_zero   = (r_room == CNT_W'(0));
    assign o_sts.mag_zero    = (r_mag == '0);
    assign o_sts.cnt_lt_room = (r_cnt < r_room);
    assign o_sts.cnt_zero    = (r_cnt == CNT_W'(0));
    assign o_sts.digit_last  = (r_func != FUNC_DEC) || chunk_last;
    assign o_sts.neg         = r_neg;

    assign o_valid    = r_valid;
    assign o_char_out = r_char;
    assign o_last     = r_last;

endmodule

`default_nettype wire

### sv/integer_to_ascii_radix.sv
// top level of the integer to ascii block: controller plus datapath
// depends on itoa_pkg, itoa_ctrl, itoa_dp and integer_to_ascii_radix_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_radix_macros.svh"

// integer to ascii conversion, one item at a time
// - an item (func, value, max_chars) is taken when i_start is high and o_busy low
// - func 0 gives signed decimal, 1 lower-case hex, 2 octal of the bit pattern;
//   func 3 gives only the terminator
// - characters come out most significant first, one per cycle on o_valid,
//   followed by a nul with o_last set; o_valid is a one-cycle strobe and
//   cannot be stalled, so the receiver must take every character as it comes
// - at most max_chars-1 characters (never more than 11) are kept; digits are
//   found least significant first, so truncation drops the top digits, and
//   the minus sign is dropped when there is no room for it
// - sequence after the start cycle: zero check, digit extraction, sign, then
//   emission; o_busy stays high throughout, and the nul is on the ports in
//   the first idle cycle, where a new item may already start
// - decimal digits come from a byte-wise long division by ten, a full pass
//   over the magnitude bytes per digit; hex and octal digits need no division
// - the digit store is a small register file inside the datapath, no clearing

module integer_to_ascii_radix import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire  [1:0]                    i_func,
    input  wire  signed [VALUE_WIDTH-1:0] i_value,
    input  wire  [3:0]                    i_max_chars,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic [7:0]                    o_char_out,
    output logic                          o_last
);

    // command and status buses between the two halves
    t_cmd cmd;
    t_sts sts;

    // sequencing: load, zero check, digit loop, sign, emit
    itoa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // magnitude register, digit unit, digit store and output register
    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_func),
        .i_value     (i_value),
        .i_max_chars (i_max_chars),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_char_out  (o_char_out),
        .o_last      (o_last)
    );

    // an accepted item keeps the block busy in the next cycle
    `ITOA_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    // the terminator is a strobed nul
    `ITOA_ASSERT_NOW(a_last_is_nul, i_clk, i_rst_n, o_last && o_valid, o_char_out == CHAR_NUL)
    // the terminator ends the item: the block is idle while it is shown
    `ITOA_ASSERT_NOW(a_idle_on_nul, i_clk, i_rst_n, o_valid && o_last, !o_busy)
    // no ordinary character appears while idle
    `ITOA_ASSERT_NOW(a_char_only_busy, i_clk, i_rst_n, o_valid && !o_busy, o_last)
    // load only happens from the idle state
    `ITOA_ASSERT_NOW(a_load_when_idle, i_clk, i_rst_n, cmd.load, !o_busy && i_start)

endmodule

`default_nettype wire

### bench/testbench.sv
// self-checking bench for integer_to_ascii_radix: directed and random items,
// each string predicted in the bench and compared character by character
// depends on itoa_pkg and the integer_to_ascii_radix rtl
`timescale 1ns / 1ps

module testbench;
    import itoa_pkg::*;

    localparam int VALUE_W = 32;
    localparam int KEEP_MAX = 11;       // characters kept at most, whatever the size says
    localparam int TAIL_CYCLES = 70;    // margin past the slowest decimal item
    localparam int DRAIN_LIMIT = 5000;

    // mode code with no conversion behind it
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    localparam logic [7:0] ASCII_NUL = 8'h00;
    localparam logic [7:0] ASCII_ZERO = "0";
    localparam logic [7:0] ASCII_LOWER_A = "a";
    localparam logic [7:0] ASCII_MINUS = "-";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_exp;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic [1:0]                i_func = FUNC_DEC;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic [3:0]                i_max_chars = '0;
    logic                      o_busy;
    logic                      o_valid;
    logic [7:0]                o_char_out;
    logic                      o_last;

    // characters still owed by the block, oldest first
    t_char_exp char_expect_q[$];

    int error_count = 0;
    int chars_checked = 0;
    int items_sent = 0;
    int strings_done = 0;
    int mode_count[4] = '{0, 0, 0, 0};

    integer_to_ascii_radix #(
        .VALUE_WIDTH(VALUE_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_max_chars(i_max_chars),
        .o_busy     (o_busy),
        .o_valid    (o_valid),
        .o_char_out (o_char_out),
        .o_last     (o_last)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // --------------------------------------------------------------------
    // string prediction: digits least significant first, truncated to the
    // room left in the buffer, sign only if it still fits, then reversed
    // --------------------------------------------------------------------
    task automatic predict_string(input logic [1:0] func, input logic signed [VALUE_W-1:0] value,
                                  input logic [3:0] size);
        logic [VALUE_W-1:0] magnitude;
        logic [7:0]         digits[$];
        int unsigned        radix;
        int unsigned        digit;
        int                 room;
        logic               negative;
        room = (size > 0) ? int'(size) - 1 : 0;
        if (room > KEEP_MAX) begin
            room = KEEP_MAX;
        end
        negative = 1'b0;
        magnitude = value;
        radix = 10;
        case (func)
            FUNC_DEC: begin
                // two's complement negate gives the true magnitude, the most
                // negative value included
                negative = value[VALUE_W-1];
                if (negative) begin
                    magnitude = -value;
                end
            end
            FUNC_HEX: radix = 16;
            FUNC_OCT: radix = 8;
            default:  room = 0;
        endcase
        if (room > 0) begin
            if (magnitude == 0) begin
                digits.push_back(ASCII_ZERO);
            end else begin
                while (magnitude != 0 && digits.size() < room) begin
                    digit = magnitude % radix;
                    magnitude = magnitude / radix;
                    if (digit < 10) begin
                        digits.push_back(ASCII_ZERO + 8'(digit));
                    end else begin
                        digits.push_back(ASCII_LOWER_A + 8'(digit - 10));
                    end
                end
                if (negative && digits.size() < room) begin
                    digits.push_back(ASCII_MINUS);
                end
            end
        end
        while (digits.size() > 0) begin
            char_expect_q.push_back('{ch: digits.pop_back(), last: 1'b0});
        end
        char_expect_q.push_back('{ch: ASCII_NUL, last: 1'b1});
    endtask

    // --------------------------------------------------------------------
    // result checker: every strobed character is taken at the edge that
    // ends its cycle, the block cannot be held off
    // --------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_char_exp exp_char;
        if (i_rst_n && o_valid === 1'b1) begin
            if (char_expect_q.size() == 0) begin
                $error("unexpected character 8'h%02h (last %0b) with nothing pending",
                       o_char_out, o_last);
                error_count++;
            end else begin
                exp_char = char_expect_q.pop_front();
                chars_checked++;
                if (o_char_out !== exp_char.ch) begin
                    $error("char_out mismatch: expected 8'h%02h, actual 8'h%02h",
                           exp_char.ch, o_char_out);
                    error_count++;
                end
                if (o_last !== exp_char.last) begin
                    $error("last mismatch: expected %0b, actual %0b", exp_char.last, o_last);
                    error_count++;
                end
                if (exp_char.last) begin
                    strings_done++;
                end
            end
        end
    end

    // mostly short gaps, now and then a long one that can leave the block idle
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [1:0] rand_func();
        if ($urandom_range(0, 19) == 0) begin
            return FUNC_UNKNOWN;
        end
        return 2'($urandom_range(0, 2));
    endfunction

    // mix of full-range patterns, small magnitudes and the boundaries
    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 20);
            2: v = -$signed(VALUE_W'($urandom_range(1, 20)));
            3: begin
                case ($urandom_range(0, 4))
                    0: v = {1'b1, {(VALUE_W-1){1'b0}}};
                    1: v = {1'b0, {(VALUE_W-1){1'b1}}};
                    2: v = '0;
                    3: v = '1;
                    default: v = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
                endcase
            end
            4: begin
                v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
                if ($urandom_range(0, 1) == 1) begin
                    v = v - 1;
                end
            end
            default: begin
                v = $urandom_range(0, 99999);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // one item: optional gap with start low, then hold start until taken;
    // start is left high so a back-to-back item needs no second assignment
    task automatic send_item(input logic [1:0] func, input logic signed [VALUE_W-1:0] value,
                             input logic [3:0] size, input int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_func <= func;
        i_value <= value;
        i_max_chars <= size;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_string(func, value, size);
        items_sent++;
        mode_count[func]++;
    endtask

    // sender pauses until the block has returned every pending character
    task automatic drain_block();
        int waited;
        waited = 0;
        i_start <= 1'b0;
        @(posedge i_clk);
        while (char_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (char_expect_q.size() != 0) begin
            $error("%0d characters still pending after %0d cycles",
                   char_expect_q.size(), DRAIN_LIMIT);
            error_count++;
        end
    endtask

    // zeros, empty buffers, most negative value, dropped sign, truncation,
    // unknown mode and every digit letter
    task automatic test_directed();
        send_item(FUNC_DEC, 0, 4'd2, pick_gap());
        send_item(FUNC_HEX, 0, 4'd15, pick_gap());
        send_item(FUNC_OCT, 0, 4'd12, pick_gap());
        send_item(FUNC_DEC, 0, 4'd1, pick_gap());
        send_item(FUNC_DEC, 12345, 4'd0, pick_gap());
        send_item(FUNC_DEC, 32'sh8000_0000, 4'd15, pick_gap());
        send_item(FUNC_DEC, 32'sh8000_0000, 4'd11, pick_gap());
        send_item(FUNC_DEC, 32'sh7fff_ffff, 4'd12, pick_gap());
        send_item(FUNC_HEX, -1, 4'd15, pick_gap());
        send_item(FUNC_OCT, -1, 4'd15, pick_gap());
        send_item(FUNC_OCT, 32'sh8000_0000, 4'd12, pick_gap());
        send_item(FUNC_DEC, -1, 4'd2, pick_gap());
        send_item(FUNC_DEC, -7, 4'd3, pick_gap());
        send_item(FUNC_DEC, 987654321, 4'd4, pick_gap());
        send_item(FUNC_HEX, 32'shdead_beef, 4'd5, pick_gap());
        send_item(FUNC_HEX, 32'sh0123_abcd, 4'd9, pick_gap());
        send_item(FUNC_OCT, 32'so1234567, 4'd15, pick_gap());
        send_item(FUNC_UNKNOWN, -1, 4'd15, pick_gap());
        send_item(FUNC_UNKNOWN, 0, 4'd0, pick_gap());
        send_item(FUNC_HEX, 32'shaaaa_aaaa, 4'd15, pick_gap());
        send_item(FUNC_HEX, 32'sh5555_5555, 4'd15, pick_gap());
        send_item(FUNC_DEC, -1000000000, 4'd15, pick_gap());
        send_item(FUNC_DEC, 7, 4'd1, pick_gap());
        drain_block();
    endtask

    // random items of every mode and size with random gaps
    task automatic test_random_mix(input int count);
        repeat (count) begin
            send_item(rand_func(), rand_value(), 4'($urandom_range(0, 15)), pick_gap());
        end
        drain_block();
    endtask

    // start held high the whole time: a new item goes in on the idle cycle
    // that carries the terminator of the previous one
    task automatic test_back_to_back(input int count);
        repeat (count) begin
            send_item(rand_func(), rand_value(), 4'($urandom_range(0, 15)), 0);
        end
        drain_block();
    endtask

    // tiny buffers, mostly negative decimals, so truncation and the dropped
    // sign come up often
    task automatic test_short_buffers(input int count);
        logic [1:0] func;
        logic signed [VALUE_W-1:0] value;
        repeat (count) begin
            func = ($urandom_range(0, 3) == 0) ? rand_func() : FUNC_DEC;
            value = rand_value();
            if (func == FUNC_DEC && $urandom_range(0, 3) != 0 && !value[VALUE_W-1]) begin
                value = -value;
            end
            send_item(func, value, 4'($urandom_range(0, 5)), pick_gap());
        end
        drain_block();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mix(200);
        test_back_to_back(80);
        test_short_buffers(70);

        // let anything stray come out before the last look at the queue
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (char_expect_q.size() != 0) begin
            $error("%0d expected characters never arrived", char_expect_q.size());
            error_count++;
        end

        $display("%0d items sent (decimal %0d, hex %0d, octal %0d, unknown mode %0d)",
                 items_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
        $display("%0d strings and %0d characters compared, %0d errors",
                 strings_done, chars_checked, error_count);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #10_000_000;
        $display("timeout waiting for the block");
        $display("status: fail");
        $finish;
    end

endmodule
